[design/slum_pkg.sv]
// Shared types, constants and helpers for the span list union merge block.
package slum_pkg;

	localparam int LIST_DEPTH  = 16;
	localparam int LEN_BITS    = 32;
	localparam int IDX_W       = $clog2(LIST_DEPTH);
	localparam int CNT_W       = $clog2(LIST_DEPTH + 1);
	localparam int NUM_BANKS   = 2;
	localparam int BANK_W      = $clog2(NUM_BANKS);
	localparam int RAM_DEPTH   = NUM_BANKS * LIST_DEPTH;
	localparam int RAM_AW      = BANK_W + IDX_W;
	localparam int MAX_RUNS    = 2 * LIST_DEPTH - 1;
	localparam int NOUT_W      = $clog2(MAX_RUNS + 1);
	localparam int JOB_Q_DEPTH = NUM_BANKS;
	localparam int JOB_Q_AW    = $clog2(JOB_Q_DEPTH);
	localparam int JOB_Q_LW    = $clog2(JOB_Q_DEPTH + 1);
	localparam int RUN_Q_DEPTH = 4;
	localparam int RUN_Q_AW    = $clog2(RUN_Q_DEPTH);
	localparam int RUN_Q_LW    = $clog2(RUN_Q_DEPTH + 1);

	typedef logic [1:0]          color_t;
	typedef logic [LEN_BITS-1:0] len_t;

	localparam color_t COL_WHITE = 2'd0;
	localparam color_t COL_GRAY  = 2'd1;
	localparam color_t COL_BLACK = 2'd2;
	localparam color_t COL_RSVD  = 2'd3;

	typedef struct packed {
		logic        list_sel;
		logic [1:0]  seg_color;
		logic [31:0] seg_length;
		logic        seg_last;
	} seg_req_t;

	typedef struct packed {
		logic [1:0]  run_color;
		logic [31:0] run_length;
		logic        run_last;
		logic        dropped;
	} run_rsp_t;

	// One stored segment
	typedef struct packed {
		len_t   len;
		color_t color;
	} seg_ent_t;

	typedef struct packed {
		logic              en;
		logic [RAM_AW-1:0] addr;
		seg_ent_t          data;
	} ram_wr_t;

	// A complete pair of lists, ready for merging
	typedef struct packed {
		logic [BANK_W-1:0] bank;
		logic [CNT_W-1:0]  cnt_a;
		logic [CNT_W-1:0]  cnt_b;
		logic              drop;
	} job_t;

	// One cut piece, or the end-of-list marker when fin is set
	typedef struct packed {
		logic   valid;
		logic   fin;
		color_t color;
		len_t   len;
		logic   drop;
	} piece_t;

	typedef enum logic [1:0] {
		WK_IDLE,
		WK_FETCH,
		WK_STEP
	} walk_state_t;

	function automatic color_t color_max(color_t a, color_t b);
		return (a > b) ? a : b;
	endfunction

	function automatic len_t sat_add(len_t a, len_t b);
		logic [LEN_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[LEN_BITS] ? '1 : s[LEN_BITS-1:0];
	endfunction

endpackage

[design/slum_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module slum_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[design/slum_front.sv]
// Front end: accepts segments, stores them per list and bank, hands off complete pairs.
module slum_front import slum_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  seg_req_t seg,
	input  logic     job_full,
	output ram_wr_t  wr_a,
	output ram_wr_t  wr_b,
	output logic     job_push,
	output job_t     job
);

	logic [CNT_W-1:0]  cnt_a_q, cnt_b_q, cnt_a_n, cnt_b_n;
	logic              done_a_q, done_b_q, done_a_n, done_b_n;
	logic              drop_q, drop_n;
	logic [BANK_W-1:0] bank_q;
	logic              acc;
	seg_ent_t          ent;

	always_comb begin
		acc       = push && !job_full;
		ent.len   = LEN_BITS'(seg.seg_length);
		ent.color = (seg.seg_color == COL_RSVD) ? COL_BLACK : seg.seg_color;
		cnt_a_n   = cnt_a_q;
		cnt_b_n   = cnt_b_q;
		done_a_n  = done_a_q;
		done_b_n  = done_b_q;
		drop_n    = drop_q;
		wr_a.en   = 1'b0;
		wr_a.addr = {bank_q, cnt_a_q[IDX_W-1:0]};
		wr_a.data = ent;
		wr_b.en   = 1'b0;
		wr_b.addr = {bank_q, cnt_b_q[IDX_W-1:0]};
		wr_b.data = ent;
		if (acc) begin
			if (!seg.list_sel) begin
				if (done_a_q) begin
					drop_n = 1'b1;
				end else begin
					if (cnt_a_q < CNT_W'(LIST_DEPTH)) begin
						wr_a.en = 1'b1;
						cnt_a_n = cnt_a_q + CNT_W'(1);
					end else begin
						drop_n = 1'b1;
					end
					if (seg.seg_last) begin
						done_a_n = 1'b1;
					end
				end
			end else begin
				if (done_b_q) begin
					drop_n = 1'b1;
				end else begin
					if (cnt_b_q < CNT_W'(LIST_DEPTH)) begin
						wr_b.en = 1'b1;
						cnt_b_n = cnt_b_q + CNT_W'(1);
					end else begin
						drop_n = 1'b1;
					end
					if (seg.seg_last) begin
						done_b_n = 1'b1;
					end
				end
			end
		end
		job_push  = acc && done_a_n && done_b_n;
		job.bank  = bank_q;
		job.cnt_a = cnt_a_n;
		job.cnt_b = cnt_b_n;
		job.drop  = drop_n;
	end

	// Hand the pair to the back end and start filling the other bank
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_a_q  <= '0;
			cnt_b_q  <= '0;
			done_a_q <= 1'b0;
			done_b_q <= 1'b0;
			drop_q   <= 1'b0;
			bank_q   <= '0;
		end else if (job_push) begin
			cnt_a_q  <= '0;
			cnt_b_q  <= '0;
			done_a_q <= 1'b0;
			done_b_q <= 1'b0;
			drop_q   <= 1'b0;
			bank_q   <= bank_q + BANK_W'(1);
		end else if (acc) begin
			cnt_a_q  <= cnt_a_n;
			cnt_b_q  <= cnt_b_n;
			done_a_q <= done_a_n;
			done_b_q <= done_b_n;
			drop_q   <= drop_n;
		end
	end

endmodule

[design/slum_job_q.sv]
// Short queue of complete list pairs between the front and back ends.
module slum_job_q import slum_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  job_t wdata,
	input  logic rd,
	output job_t head,
	output logic full,
	output logic empty
);

	job_t                mem_q [JOB_Q_DEPTH];
	logic [JOB_Q_AW-1:0] wp_q, rp_q;
	logic [JOB_Q_LW-1:0] lvl_q;

	assign full  = (lvl_q == JOB_Q_LW'(JOB_Q_DEPTH));
	assign empty = (lvl_q == '0);
	assign head  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			lvl_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= wp_q + JOB_Q_AW'(1);
			end
			if (rd) begin
				rp_q <= rp_q + JOB_Q_AW'(1);
			end
			lvl_q <= lvl_q + JOB_Q_LW'(wr) - JOB_Q_LW'(rd);
		end
	end

endmodule

[design/slum_run_q.sv]
// Output queue of merged runs.
module slum_run_q import slum_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr,
	input  run_rsp_t            wdata,
	input  logic                rd,
	output run_rsp_t            head,
	output logic                empty,
	output logic [RUN_Q_LW-1:0] level
);

	run_rsp_t            mem_q [RUN_Q_DEPTH];
	logic [RUN_Q_AW-1:0] wp_q, rp_q;
	logic [RUN_Q_LW-1:0] lvl_q;
	logic                rd_ok;

	assign rd_ok = rd && (lvl_q != '0);
	assign empty = (lvl_q == '0);
	assign head  = mem_q[rp_q];
	assign level = lvl_q;

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			lvl_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= wp_q + RUN_Q_AW'(1);
			end
			if (rd_ok) begin
				rp_q <= rp_q + RUN_Q_AW'(1);
			end
			lvl_q <= lvl_q + RUN_Q_LW'(wr) - RUN_Q_LW'(rd_ok);
		end
	end

endmodule

[design/slum_back.sv]
// Back end: walks both stored lists, cuts pieces, coalesces them into runs.
module slum_back import slum_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                job_empty,
	input  job_t                job,
	output logic                job_pop,
	output logic [RAM_AW-1:0]   rd_addr_a,
	output logic [RAM_AW-1:0]   rd_addr_b,
	input  seg_ent_t            rd_a,
	input  seg_ent_t            rd_b,
	input  logic [RUN_Q_LW-1:0] rq_level,
	output logic                rq_push,
	output run_rsp_t            rq_data
);

	walk_state_t       state_q, state_n;
	logic [CNT_W-1:0]  ia_q, ib_q;
	len_t              ra_q, rb_q, ra_n, rb_n;
	color_t            ca_q, cb_q;
	logic              need_a_q, need_b_q;
	logic              a_live, b_live, adv_a, adv_b, room, step_go, start;
	len_t              eff_a, eff_b;
	color_t            eff_ca, eff_cb;
	logic [LEN_BITS:0] diff;
	logic              a_lt;
	logic [RUN_Q_LW:0] need_lvl;
	piece_t            piece, tok_s1;

	logic              open_q, open_n;
	color_t            cur_color_q, cur_color_n;
	len_t              cur_len_q, cur_len_n;
	logic [NOUT_W-1:0] nout_q, nout_n;

	assign rd_addr_a = {job.bank, ia_q[IDX_W-1:0]};
	assign rd_addr_b = {job.bank, ib_q[IDX_W-1:0]};

	// Walker datapath
	always_comb begin
		a_live   = ia_q < job.cnt_a;
		b_live   = ib_q < job.cnt_b;
		eff_a    = need_a_q ? rd_a.len : ra_q;
		eff_b    = need_b_q ? rd_b.len : rb_q;
		eff_ca   = need_a_q ? rd_a.color : ca_q;
		eff_cb   = need_b_q ? rd_b.color : cb_q;
		diff     = {1'b0, eff_a} - {1'b0, eff_b};
		a_lt     = diff[LEN_BITS];
		need_lvl = (RUN_Q_LW + 1)'(rq_level) + (RUN_Q_LW + 1)'(tok_s1.valid);
		room     = need_lvl < (RUN_Q_LW + 1)'(RUN_Q_DEPTH);
	end

	// Walker next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			WK_IDLE: begin
				if (!job_empty) begin
					state_n = WK_FETCH;
				end
			end
			WK_FETCH: begin
				state_n = WK_STEP;
			end
			WK_STEP: begin
				if (room) begin
					state_n = (!a_live && !b_live) ? WK_IDLE : WK_FETCH;
				end
			end
			default: state_n = WK_IDLE;
		endcase
	end

	// Walker outputs
	always_comb begin
		start       = (state_q == WK_IDLE) && !job_empty;
		step_go     = (state_q == WK_STEP) && room;
		job_pop     = 1'b0;
		adv_a       = 1'b0;
		adv_b       = 1'b0;
		ra_n        = eff_a;
		rb_n        = eff_b;
		piece.valid = 1'b0;
		piece.fin   = 1'b0;
		piece.color = COL_WHITE;
		piece.len   = '0;
		piece.drop  = job.drop;
		if (step_go) begin
			piece.valid = 1'b1;
			priority if (!a_live && !b_live) begin
				piece.fin = 1'b1;
				job_pop   = 1'b1;
			end else if (!a_live) begin
				piece.color = eff_cb;
				piece.len   = eff_b;
				adv_b       = 1'b1;
			end else if (!b_live) begin
				piece.color = eff_ca;
				piece.len   = eff_a;
				adv_a       = 1'b1;
			end else begin
				piece.color = color_max(eff_ca, eff_cb);
				piece.len   = a_lt ? eff_a : eff_b;
				ra_n        = a_lt ? '0 : diff[LEN_BITS-1:0];
				rb_n        = a_lt ? (len_t'(0) - diff[LEN_BITS-1:0]) : '0;
				adv_a       = (ra_n == '0);
				adv_b       = (rb_n == '0);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= WK_IDLE;
			ia_q     <= '0;
			ib_q     <= '0;
			need_a_q <= 1'b0;
			need_b_q <= 1'b0;
			tok_s1   <= '0;
		end else begin
			state_q <= state_n;
			tok_s1  <= piece;
			if (start) begin
				ia_q     <= '0;
				ib_q     <= '0;
				need_a_q <= 1'b1;
				need_b_q <= 1'b1;
			end else if (step_go) begin
				ia_q     <= ia_q + CNT_W'(adv_a);
				ib_q     <= ib_q + CNT_W'(adv_b);
				need_a_q <= adv_a;
				need_b_q <= adv_b;
			end
		end
	end

	// Hold the remaining length and colour of a partly cut segment
	always_ff @(posedge clk) begin
		if (step_go) begin
			ra_q <= ra_n;
			rb_q <= rb_n;
			ca_q <= eff_ca;
			cb_q <= eff_cb;
		end
	end

	// Coalescer
	always_comb begin
		open_n             = open_q;
		cur_color_n        = cur_color_q;
		cur_len_n          = cur_len_q;
		nout_n             = nout_q;
		rq_push            = 1'b0;
		rq_data.run_color  = cur_color_q;
		rq_data.run_length = 32'(cur_len_q);
		rq_data.run_last   = 1'b0;
		rq_data.dropped    = tok_s1.drop;
		if (tok_s1.valid) begin
			if (tok_s1.fin) begin
				rq_push            = 1'b1;
				rq_data.run_color  = open_q ? cur_color_q : COL_WHITE;
				rq_data.run_length = open_q ? 32'(cur_len_q) : 32'd0;
				rq_data.run_last   = 1'b1;
				open_n             = 1'b0;
				nout_n             = '0;
			end else if (tok_s1.len != '0) begin
				priority if (!open_q) begin
					open_n      = 1'b1;
					cur_color_n = tok_s1.color;
					cur_len_n   = tok_s1.len;
				end else if (tok_s1.color == cur_color_q ||
						nout_q >= NOUT_W'(MAX_RUNS - 1)) begin
					cur_len_n = sat_add(cur_len_q, tok_s1.len);
				end else begin
					rq_push     = 1'b1;
					nout_n      = nout_q + NOUT_W'(1);
					cur_color_n = tok_s1.color;
					cur_len_n   = tok_s1.len;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			nout_q <= '0;
		end else begin
			open_q <= open_n;
			nout_q <= nout_n;
		end
	end

	always_ff @(posedge clk) begin
		cur_color_q <= cur_color_n;
		cur_len_q   <= cur_len_n;
	end

endmodule

[design/span_list_union_merge.sv]
// Span list union merge. Segments of two run-length lists (A and B) are pushed one per
// cycle while full is low; each list closes with its last flag. When both lists are closed
// the pair is handed to the merge engine and the front end immediately starts filling a
// second store bank, so loading the next pair overlaps merging the current one; full rises
// only while both banks hold unmerged pairs. The merge engine cuts the two lists at every
// boundary; each cut piece takes a fetch state for the store read and a step state for
// the cut, and the step waits while the result queue lacks room. Cut pieces are
// registered before they are coalesced into runs.
// Runs come out of a four-entry result queue; dropped reports lost segments of that pair.
module span_list_union_merge import slum_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  seg_req_t seg,
	output logic     empty,
	input  logic     pop,
	output run_rsp_t run
);

	ram_wr_t             wr_a, wr_b;
	logic                job_push, job_pop, job_full, job_empty;
	job_t                job_in, job_head;
	logic [RAM_AW-1:0]   rd_addr_a, rd_addr_b;
	seg_ent_t            rd_a, rd_b;
	logic                rq_push;
	run_rsp_t            rq_data;
	logic [RUN_Q_LW-1:0] rq_level;

	// Stall the input while both banks hold pairs waiting for the merge
	assign full = job_full;

	slum_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.seg      (seg),
		.job_full (job_full),
		.wr_a     (wr_a),
		.wr_b     (wr_b),
		.job_push (job_push),
		.job      (job_in)
	);

	// First-list store, two banks
	slum_ram #(
		.WIDTH ($bits(seg_ent_t)),
		.DEPTH (RAM_DEPTH)
	) u_store_a (
		.clk   (clk),
		.we    (wr_a.en),
		.waddr (wr_a.addr),
		.wdata (wr_a.data),
		.raddr (rd_addr_a),
		.rdata (rd_a)
	);

	// Second-list store, two banks
	slum_ram #(
		.WIDTH ($bits(seg_ent_t)),
		.DEPTH (RAM_DEPTH)
	) u_store_b (
		.clk   (clk),
		.we    (wr_b.en),
		.waddr (wr_b.addr),
		.wdata (wr_b.data),
		.raddr (rd_addr_b),
		.rdata (rd_b)
	);

	slum_job_q u_job_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (job_push),
		.wdata  (job_in),
		.rd     (job_pop),
		.head   (job_head),
		.full   (job_full),
		.empty  (job_empty)
	);

	slum_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_empty (job_empty),
		.job       (job_head),
		.job_pop   (job_pop),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.rd_a      (rd_a),
		.rd_b      (rd_b),
		.rq_level  (rq_level),
		.rq_push   (rq_push),
		.rq_data   (rq_data)
	);

	slum_run_q u_run_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (rq_push),
		.wdata  (rq_data),
		.rd     (pop),
		.head   (run),
		.empty  (empty),
		.level  (rq_level)
	);

	// A pair is never handed off while both banks are busy
	a_job_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |-> !job_full)
		else $error("pair request pushed into a full job queue");

	// The merge engine only retires a pair that is present
	a_job_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> !job_empty)
		else $error("job queue popped while empty");

	// Room check in the merge engine keeps the result queue from overflowing
	a_run_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		rq_push |-> (rq_level != RUN_Q_LW'(RUN_Q_DEPTH)))
		else $error("run request pushed into a full result queue");

	// A pair with no pending merge cannot make the front stall
	a_full_needs_jobs: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !job_empty)
		else $error("input stalled with no pair waiting");

endmodule

[verif/run_merge_checker.sv]
// Checker for the span list union merge: predicts merged runs per pair of lists and compares them.
module run_merge_checker import slum_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  logic     full,
	input  seg_req_t seg,
	input  logic     empty,
	input  logic     pop,
	input  run_rsp_t run,
	output int       fails,
	output int       pending
);

	color_t      col_mem [2][LIST_DEPTH];
	len_t        len_mem [2][LIST_DEPTH];
	int unsigned fill [2];
	logic        closed [2];
	logic        lost;

	// coalescing state of the burst being built
	logic        run_open;
	color_t      run_col;
	len_t        run_len;
	int          emitted;

	run_rsp_t    runs_due [$];
	int          fail_total = 0;

	assign fails = fail_total;

	task automatic report(input string msg);
		$display("mismatch: %s", msg);
		fail_total++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report($sformatf("%s got %0h, want %0h", name, got, want));
	endtask

	task automatic emit_run(input color_t c, input len_t n, input logic last);
		run_rsp_t r;
		r.run_color  = c;
		r.run_length = n;
		r.run_last   = last;
		r.dropped    = lost;
		runs_due = {runs_due, r};
		emitted++;
	endtask

	task automatic add_piece(input color_t c, input len_t n);
		logic [LEN_BITS:0] wide;
		if (n != '0) begin
			if (!run_open) begin
				run_open = 1'b1;
				run_col  = c;
				run_len  = n;
			end else if (c == run_col || emitted >= MAX_RUNS - 1) begin
				// saturate; the last slot swallows everything once runs run out
				wide    = {1'b0, run_len} + {1'b0, n};
				run_len = wide[LEN_BITS] ? '1 : wide[LEN_BITS-1:0];
			end else begin
				emit_run(run_col, run_len, 1'b0);
				run_col = c;
				run_len = n;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		int       l;
		int       ia;
		int       ib;
		color_t   c;
		color_t   ca;
		color_t   cb;
		len_t     ra;
		len_t     rb;
		len_t     cut;
		run_rsp_t want;
		if (!arst_n) begin
			fill[0]   = 0;
			fill[1]   = 0;
			closed[0] = 1'b0;
			closed[1] = 1'b0;
			lost      = 1'b0;
			runs_due.delete();
			pending  <= 0;
		end else begin
			if (pop && !empty) begin
				if (runs_due.size() == 0) begin
					report($sformatf("unexpected run color %0d length %0h last %0b dropped %0b",
						run.run_color, run.run_length, run.run_last, run.dropped));
				end else begin
					want = runs_due.pop_front();
					check_field("run_color", run.run_color, want.run_color);
					check_field("run_length", run.run_length, want.run_length);
					check_field("run_last", run.run_last, want.run_last);
					check_field("dropped", run.dropped, want.dropped);
				end
			end
			if (push && !full) begin
				l = seg.list_sel;
				c = (seg.seg_color == COL_RSVD) ? COL_BLACK : seg.seg_color;
				if (closed[l]) begin
					lost = 1'b1;
				end else begin
					if (fill[l] < LIST_DEPTH) begin
						col_mem[l][fill[l]] = c;
						len_mem[l][fill[l]] = len_t'(seg.seg_length);
						fill[l]++;
					end else begin
						lost = 1'b1;
					end
					if (seg.seg_last)
						closed[l] = 1'b1;
				end
				if (closed[0] && closed[1]) begin
					// cut both lists at every boundary and take the larger colour
					emitted  = 0;
					run_open = 1'b0;
					run_col  = COL_WHITE;
					run_len  = '0;
					ia = 0;
					ib = 0;
					ra = (fill[0] > 0) ? len_mem[0][0] : '0;
					rb = (fill[1] > 0) ? len_mem[1][0] : '0;
					while (ia < fill[0] || ib < fill[1]) begin
						if (ia >= fill[0]) begin
							add_piece(col_mem[1][ib], rb);
							ib++;
							if (ib < fill[1])
								rb = len_mem[1][ib];
						end else if (ib >= fill[1]) begin
							add_piece(col_mem[0][ia], ra);
							ia++;
							if (ia < fill[0])
								ra = len_mem[0][ia];
						end else begin
							ca  = col_mem[0][ia];
							cb  = col_mem[1][ib];
							cut = (ra < rb) ? ra : rb;
							add_piece((ca > cb) ? ca : cb, cut);
							ra = ra - cut;
							rb = rb - cut;
							if (ra == '0) begin
								ia++;
								if (ia < fill[0])
									ra = len_mem[0][ia];
							end
							if (rb == '0) begin
								ib++;
								if (ib < fill[1])
									rb = len_mem[1][ib];
							end
						end
					end
					if (run_open)
						emit_run(run_col, run_len, 1'b1);
					else
						emit_run(COL_WHITE, '0, 1'b1);
					fill[0]   = 0;
					fill[1]   = 0;
					closed[0] = 1'b0;
					closed[1] = 1'b0;
					lost      = 1'b0;
				end
			end
			pending <= runs_due.size();
		end
	end

endmodule

[verif/span_list_union_merge_tb.sv]
// Testbench top for the span list union merge: stimulus, idling, watchdog and verdict.
module span_list_union_merge_tb;
	import slum_pkg::*;

	localparam int QUIET_LIMIT  = 3000;  // cycles with no request moving on either side
	localparam int HOLD_CYCLES  = 400;   // long receiver hold-off to fill the block
	localparam int HOLD_AFTER   = 120;   // accepted requests before the hold-off starts
	localparam int RANDOM_REQS  = 350;
	localparam int DRAIN_CYCLES = 80;    // above the worst merge latency of a full pair

	logic     clk = 1'b0;
	logic     arst_n;
	logic     push;
	logic     full;
	seg_req_t seg;
	logic     empty;
	logic     pop;
	run_rsp_t run;

	int       fails;
	int       pending;
	logic     calm = 1'b0;      // set: neither side idles
	int       accepted_reqs = 0;
	int       quiet = 0;
	int       sent;

	span_list_union_merge dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.seg    (seg),
		.empty  (empty),
		.pop    (pop),
		.run    (run)
	);

	run_merge_checker u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.seg     (seg),
		.empty   (empty),
		.pop     (pop),
		.run     (run),
		.fails   (fails),
		.pending (pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(12, 40);
	endfunction

	// Lengths: mostly short, some zero, some anywhere in the 32-bit range, some near all ones.
	function automatic logic [31:0] pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return '0;
		else if (r < 85)
			return $urandom_range(1, 64);
		else if (r < 93)
			return $urandom();
		else
			return 32'hFFFF_FFFF - $urandom_range(0, 3);
	endfunction

	// Alternating colours on both lists make many short runs and reach the run limit.
	function automatic color_t pick_color(input logic alt, input logic sel, input int i);
		if (!alt)
			return color_t'($urandom_range(COL_WHITE, COL_RSVD));
		else if (!sel)
			return (i % 2) ? COL_BLACK : COL_WHITE;
		else
			return (i % 2) ? COL_WHITE : COL_GRAY;
	endfunction

	function automatic seg_req_t segment(input logic sel, input color_t c,
			input logic [31:0] n, input logic last);
		seg_req_t s;
		s.list_sel   = sel;
		s.seg_color  = c;
		s.seg_length = n;
		s.seg_last   = last;
		return s;
	endfunction

	// Offer one request; return at the edge where it is accepted.
	task automatic push_seg(input seg_req_t s);
		int gap;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		seg  <= s;
		do @(posedge clk); while (full);
		sent++;
	endtask

	// Send a pair of lists. With extra > 0 the lead list is sent whole first, then
	// extra requests for that closed list (all dropped), then the other list.
	task automatic offer_pair(input int na, input int nb, input logic alt, input int extra);
		seg_req_t qa [$];
		seg_req_t qb [$];
		int       i;
		int       lead;
		int       pick;
		lead = $urandom_range(0, 1);
		for (i = 0; i < na; i++)
			qa = {qa, segment(1'b0, pick_color(alt, 1'b0, i), pick_len(), i == na - 1)};
		for (i = 0; i < nb; i++)
			qb = {qb, segment(1'b1, pick_color(alt, 1'b1, i), pick_len(), i == nb - 1)};
		while (qa.size() != 0 || qb.size() != 0) begin
			if (extra > 0)
				pick = (lead == 0) ? (qa.size() != 0 ? 0 : 1) : (qb.size() != 0 ? 1 : 0);
			else if (qb.size() == 0)
				pick = 0;
			else if (qa.size() == 0)
				pick = 1;
			else
				pick = $urandom_range(0, 1);
			push_seg(pick ? qb.pop_front() : qa.pop_front());
			if (extra > 0 && (lead ? qb.size() == 0 : qa.size() == 0)) begin
				repeat (extra)
					push_seg(segment(lead[0], color_t'($urandom_range(COL_WHITE, COL_RSVD)),
						pick_len(), 1'($urandom_range(0, 1))));
				extra = 0;
			end
		end
	endtask

	// Toggle between stretches with idling and stretches without.
	initial begin
		forever begin
			repeat ($urandom_range(100, 300)) @(posedge clk);
			calm <= !calm;
		end
	end

	// Count accepted requests; the receiver keys its long hold-off on this.
	always @(posedge clk) begin
		if (push && !full)
			accepted_reqs <= accepted_reqs + 1;
	end

	// Watchdog: end the run when nothing moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			quiet <= 0;
		end else if (quiet == QUIET_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// Receiver: random stalls, plus one long hold-off while the sender keeps pushing.
	initial begin : drain_side
		int   stall;
		logic held;
		stall = 0;
		held  = 1'b0;
		pop   = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!held && accepted_reqs >= HOLD_AFTER) begin
				held = 1'b1;
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				if (stall > 0) begin
					pop <= 1'b0;
					stall--;
				end else begin
					pop <= 1'b1;
					stall = calm ? 0 : pick_gap();
				end
				@(posedge clk);
			end
		end
	end

	initial begin : feed
		int kind;
		push   = 1'b0;
		seg    = '0;
		arst_n = 1'b0;
		sent   = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// nothing but zero-length pieces: a single white run of length zero
		push_seg(segment(1'b0, COL_WHITE, 32'h0, 1'b1));
		push_seg(segment(1'b1, COL_GRAY, 32'h0, 1'b1));

		// reserved colour, saturating sums, a request for a closed list, a zero piece
		push_seg(segment(1'b0, COL_RSVD, 32'd5, 1'b0));
		push_seg(segment(1'b0, COL_BLACK, 32'hFFFF_FFFF, 1'b1));
		push_seg(segment(1'b0, COL_GRAY, 32'd7, 1'b1));
		push_seg(segment(1'b1, COL_GRAY, 32'hFFFF_FFFF, 1'b0));
		push_seg(segment(1'b1, COL_WHITE, 32'h0, 1'b0));
		push_seg(segment(1'b1, COL_WHITE, 32'd3, 1'b1));

		// second list closes first and gets a stray request; first list's tail passes through
		push_seg(segment(1'b1, COL_BLACK, 32'd2, 1'b1));
		push_seg(segment(1'b1, COL_GRAY, 32'd9, 1'b0));
		push_seg(segment(1'b0, COL_WHITE, 32'd1, 1'b0));
		push_seg(segment(1'b0, COL_GRAY, 32'd4, 1'b0));
		push_seg(segment(1'b0, COL_WHITE, 32'h8000_0000, 1'b1));

		// several colour pairings with cuts inside segments
		push_seg(segment(1'b0, COL_GRAY, 32'd16, 1'b0));
		push_seg(segment(1'b1, COL_WHITE, 32'd8, 1'b0));
		push_seg(segment(1'b0, COL_WHITE, 32'd16, 1'b1));
		push_seg(segment(1'b1, COL_BLACK, 32'd8, 1'b0));
		push_seg(segment(1'b1, COL_GRAY, 32'd16, 1'b1));

		// random pairs: mostly well formed, some overfull, some with stray requests
		sent = 0;
		while (sent < RANDOM_REQS) begin
			kind = $urandom_range(0, 99);
			if (kind < 55)
				offer_pair($urandom_range(1, 6), $urandom_range(1, 6), 1'b0, 0);
			else if (kind < 70)
				offer_pair($urandom_range(8, 16), $urandom_range(8, 16), 1'b1, 0);
			else if (kind < 76)
				offer_pair($urandom_range(17, 20), $urandom_range(1, 16), 1'b0, 0);
			else if (kind < 82)
				offer_pair($urandom_range(1, 16), $urandom_range(17, 20),
					1'($urandom_range(0, 1)), 0);
			else
				offer_pair($urandom_range(1, 5), $urandom_range(1, 5), 1'b0, $urandom_range(1, 3));
		end
		push <= 1'b0;

		// drain: wait for every predicted run, then hold for stray late output
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fails == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

[files.f]
design/slum_pkg.sv
design/slum_ram.sv
design/slum_front.sv
design/slum_job_q.sv
design/slum_run_q.sv
design/slum_back.sv
design/span_list_union_merge.sv
verif/run_merge_checker.sv
verif/span_list_union_merge_tb.sv
